// ===== src/wbps_pkg.sv =====
// Shared types and constants for the wildcard byte pattern search block.
package wbps_pkg;

  // Pattern byte that matches any data byte
  localparam logic [7:0] WILDCARD = 8'h3F;

  // Configuration port geometry
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 3;
  localparam int LENGTH_BITS    = 6;
  localparam int NUM_WORDS      = 4;
  localparam int WORD_BYTES     = 8;
  localparam int PATTERN_BYTES  = NUM_WORDS * WORD_BYTES;

  // Width of the offset field of a result
  localparam int OFFSET_FIELD_BITS = 32;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_0 = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_1 = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_2 = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_WORD_3 = 3'd4;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // Output transaction payload
  typedef struct packed {
    logic                         found;
    logic [OFFSET_FIELD_BITS-1:0] match_offset;
  } out_item_t;

  typedef logic [CFG_DATA_BITS-1:0] pattern_word_t;

endpackage

// ===== src/wildcard_byte_pattern_search.sv =====
// Top level of the wildcard byte pattern search block.
//
// Streams region bytes, one transaction per cycle while the input is not
// stalled, into a sliding window and reports the leftmost offset where the
// configured pattern (1 to 32 bytes, 0x3F matching any byte) matches: found=1
// with the start offset on the first match, or found=0 on the region's last
// byte if no match occurred. A byte passes through the window register, which
// captures it, and the output register, which the compare outcome loads. Input
// stalls only while the output register holds an untaken result and the
// compare stage is full. Pattern writes pass through the configuration
// registers and the registered alignment before they reach the compare.
module wildcard_byte_pattern_search
  import wbps_pkg::*;
#(
  parameter int MAX_PATTERN = 32,
  parameter int OFFSET_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_item_t                 out_data
);

  localparam int PAT_BYTES = (MAX_PATTERN < PATTERN_BYTES) ? MAX_PATTERN : PATTERN_BYTES;
  localparam int LEN_BITS  = $clog2(PAT_BYTES + 1);

  // Configuration registers
  logic [LENGTH_BITS-1:0] pattern_length;
  pattern_word_t          pattern_word [NUM_WORDS];

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= LENGTH_BITS'(1);
      for (int w = 0; w < NUM_WORDS; w++) begin
        pattern_word[w] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length  <= cfg_data[LENGTH_BITS-1:0];
        REG_PATTERN_WORD_0: pattern_word[0] <= cfg_data;
        REG_PATTERN_WORD_1: pattern_word[1] <= cfg_data;
        REG_PATTERN_WORD_2: pattern_word[2] <= cfg_data;
        REG_PATTERN_WORD_3: pattern_word[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Aligned pattern and mask
  logic [LEN_BITS-1:0]  len_used;
  logic [7:0]           aligned_byte [PAT_BYTES];
  logic [PAT_BYTES-1:0] compare_mask;

  wbps_align #(
    .PAT_BYTES(PAT_BYTES)
  ) u_align (
    .clk           (clk),
    .pattern_length(pattern_length),
    .pattern_word  (pattern_word),
    .len_used      (len_used),
    .aligned_byte  (aligned_byte),
    .compare_mask  (compare_mask)
  );

  // Handshake
  logic s1_valid;
  logic s1_advance;
  logic in_accept;
  logic out_accept;

  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && out_valid && out_stall;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  // Window stage: window and count as seen by the transaction held here
  logic [7:0]             window [PAT_BYTES];
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic                   s1_last;
  logic [7:0]             window_next [PAT_BYTES];
  logic [OFFSET_BITS-1:0] bytes_seen_next;
  logic [OFFSET_BITS-1:0] count_base;

  // Restart from a clear window after a region's last byte
  always_comb begin
    count_base = s1_last ? '0 : bytes_seen;
    window_next[0] = in_data.data_byte;
    for (int j = 1; j < PAT_BYTES; j++) begin
      window_next[j] = s1_last ? 8'h00 : window[j-1];
    end
    bytes_seen_next = (count_base == '1) ? count_base : count_base + OFFSET_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s1_last    <= 1'b0;
      bytes_seen <= '0;
      for (int j = 0; j < PAT_BYTES; j++) begin
        window[j] <= 8'h00;
      end
    end else begin
      if (in_accept) begin
        s1_valid   <= 1'b1;
        s1_last    <= in_data.last_byte;
        bytes_seen <= bytes_seen_next;
        window     <= window_next;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Compare stage
  logic [PAT_BYTES-1:0]         slot_ok;
  logic                         window_full;
  logic                         hit;
  logic [OFFSET_BITS-1:0]       offset_raw;
  logic [OFFSET_FIELD_BITS-1:0] offset_sat;
  logic                         already_matched;

  always_comb begin
    for (int j = 0; j < PAT_BYTES; j++) begin
      slot_ok[j] = !compare_mask[j] || (window[j] == aligned_byte[j]);
    end
  end

  assign window_full = bytes_seen >= OFFSET_BITS'(len_used);
  assign hit         = !already_matched && window_full && (&slot_ok);
  assign offset_raw  = bytes_seen - OFFSET_BITS'(len_used);

  // Offset into the 32-bit field, saturating
  generate
    if (OFFSET_BITS > OFFSET_FIELD_BITS) begin : g_offset_wide
      assign offset_sat = (|offset_raw[OFFSET_BITS-1:OFFSET_FIELD_BITS]) ? '1
                        : offset_raw[OFFSET_FIELD_BITS-1:0];
    end else begin : g_offset_narrow
      assign offset_sat = OFFSET_FIELD_BITS'(offset_raw);
    end
  endgenerate

  // Output register and per-region match flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      already_matched <= 1'b0;
    end else begin
      if (s1_advance) begin
        already_matched <= s1_last ? 1'b0 : (already_matched || hit);
      end
      if (s1_advance && hit) begin
        out_valid <= 1'b1;
      end else if (s1_advance && s1_last && !already_matched) begin
        out_valid <= 1'b1;
      end else if (out_accept) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && hit) begin
      out_data.found        <= 1'b1;
      out_data.match_offset <= offset_sat;
    end else if (s1_advance && s1_last && !already_matched) begin
      out_data.found        <= 1'b0;
      out_data.match_offset <= '0;
    end
  end

endmodule

// ===== src/wbps_align.sv =====
// Registered clamp of the pattern length and window-aligned pattern bytes and compare mask.
module wbps_align
  import wbps_pkg::*;
#(
  parameter int PAT_BYTES = 32
) (
  input  logic                               clk,
  input  logic [LENGTH_BITS-1:0]             pattern_length,
  input  pattern_word_t                      pattern_word [NUM_WORDS],
  output logic [$clog2(PAT_BYTES+1)-1:0]     len_used,
  output logic [7:0]                         aligned_byte [PAT_BYTES],
  output logic [PAT_BYTES-1:0]               compare_mask
);

  localparam int LEN_BITS  = $clog2(PAT_BYTES + 1);
  localparam int PIDX_BITS = $clog2(PAT_BYTES);

  logic [7:0]          pat_byte [PAT_BYTES];
  logic [LEN_BITS-1:0] len_next;
  logic [7:0]          aligned_next [PAT_BYTES];
  logic [PAT_BYTES-1:0] mask_next;

  // Unpack the pattern words, low byte first
  always_comb begin
    for (int i = 0; i < PAT_BYTES; i++) begin
      pat_byte[i] = pattern_word[i / WORD_BYTES][(i % WORD_BYTES) * 8 +: 8];
    end
  end

  // Clamp the length into 1..PAT_BYTES
  always_comb begin
    if (pattern_length == '0) begin
      len_next = LEN_BITS'(1);
    end else if (pattern_length > LENGTH_BITS'(PAT_BYTES)) begin
      len_next = LEN_BITS'(PAT_BYTES);
    end else begin
      len_next = LEN_BITS'(pattern_length);
    end
  end

  // Window slot j (0 = newest) lines up with pattern byte len-1-j
  always_comb begin
    logic [LEN_BITS-1:0] k;
    k = '0;
    for (int j = 0; j < PAT_BYTES; j++) begin
      k = len_next - LEN_BITS'(j) - LEN_BITS'(1);
      aligned_next[j] = pat_byte[k[PIDX_BITS-1:0]];
      mask_next[j] = (LEN_BITS'(j) < len_next) && (aligned_next[j] != WILDCARD);
    end
  end

  always_ff @(posedge clk) begin
    len_used     <= len_next;
    aligned_byte <= aligned_next;
    compare_mask <= mask_next;
  end

endmodule
